FILE: rtl/core/sac_pkg.sv
// Shared constants, types and the divider step for the swept box collision block.
`default_nettype none
package sac_pkg;

  // Number formats
  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 32;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int SUM_BITS   = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int REM_BITS   = COORD_BITS + 1;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int TIME_BITS  = FRAC_BITS + 4;
  localparam int NAXIS      = 3;
  localparam int NLANE      = 2 * NAXIS;

  // Stream packing
  localparam int IN_FIELD_BITS  = 2 * NAXIS * COORD_BITS + 2 * NAXIS * SIZE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = QUO_BITS + 2 * NAXIS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int VEL_OFS  = NAXIS * COORD_BITS;
  localparam int ASZ_OFS  = 2 * NAXIS * COORD_BITS;
  localparam int BSZ_OFS  = ASZ_OFS + NAXIS * SIZE_BITS;

  // Time constants
  localparam logic signed [TIME_BITS-1:0] ONE_T = TIME_BITS'(1) << FRAC_BITS;
  localparam logic signed [TIME_BITS-1:0] SAT_T = TIME_BITS'(2) << FRAC_BITS;
  localparam logic signed [TIME_BITS-1:0] UNB_T = TIME_BITS'(4) << FRAC_BITS;

  // Normal codes
  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  // One division lane in flight
  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [MAG_BITS-1:0] den;
    logic [QUO_BITS-1:0] quo;
    logic                sat;
    logic                neg;
    logic                unb;
  } lane_t;

  typedef lane_t [NLANE-1:0] lanes_t;

  // Item data that rides beside the division lanes
  typedef struct packed {
    logic             bp_hit;
    logic [NAXIS-1:0] dneg;
  } side_t;

  // One restoring division step: optional shift, compare, subtract, shift in bit
  function automatic lane_t div_step(lane_t l, logic shift);
    lane_t               o;
    logic [REM_BITS-1:0] trial;
    logic [REM_BITS-1:0] dext;
    logic                ge;
    o     = l;
    trial = shift ? {l.rem[REM_BITS-2:0], 1'b0} : l.rem;
    dext  = {1'b0, l.den};
    ge    = (trial >= dext);
    o.rem = ge ? (trial - dext) : trial;
    o.quo = {l.quo[QUO_BITS-2:0], ge};
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sac_div_pipe.sv
// Pipelined fixed-point divider: six lanes, one quotient bit per stage.
`default_nettype none
module sac_div_pipe (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sac_pkg::lanes_t in_lanes,
  input  wire sac_pkg::side_t  in_side,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sac_pkg::lanes_t      out_lanes,
  output sac_pkg::side_t       out_side
);

  localparam int NST = sac_pkg::QUO_BITS;

  logic [NST-1:0]  v_r;
  logic [NST-1:0]  rdy;
  sac_pkg::lanes_t lanes_r [NST];
  sac_pkg::side_t  side_r  [NST];

  genvar s, l;
  generate
    for (s = 0; s < NST; s++) begin : g_st
      logic            src_v;
      sac_pkg::lanes_t src_lanes;
      sac_pkg::side_t  src_side;
      sac_pkg::lanes_t lanes_nxt;

      // Select the stage source
      if (s == 0) begin : g_first
        assign src_v     = in_valid;
        assign src_lanes = in_lanes;
        assign src_side  = in_side;
      end else begin : g_mid
        assign src_v     = v_r[s-1];
        assign src_lanes = lanes_r[s-1];
        assign src_side  = side_r[s-1];
      end

      // Advance when empty or when downstream advances
      if (s == NST - 1) begin : g_last
        assign rdy[s] = !v_r[s] || out_ready;
      end else begin : g_chain
        assign rdy[s] = !v_r[s] || rdy[s+1];
      end

      // Produce one quotient bit per lane
      for (l = 0; l < sac_pkg::NLANE; l++) begin : g_ln
        assign lanes_nxt[l] = sac_pkg::div_step(src_lanes[l], 1'(s != 0));
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          v_r[s] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && src_v) begin
          lanes_r[s] <= lanes_nxt;
          side_r[s]  <= src_side;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  assign out_lanes = lanes_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule
`default_nettype wire

FILE: rtl/core/swept_aabb_collision_time.sv
// Top level of the swept axis-aligned box collision time block.
//
// Usage: one item on the in_ stream describes a box pair (relative position,
// relative velocity, both extents, Q16.16). Each item gives exactly one item
// on the out_ stream: the entry time in Q1.16 (1.0 on a miss) and a unit
// contact normal on the axis of latest entry (zero on a miss).
// The pipeline has 22 register stages: two front stages (input register,
// broadphase and distances), 17 divider stages that each resolve one
// quotient bit of all six entry/exit divisions, and three back stages
// (signed times, latest entry and earliest exit, hit decision).
// The pipeline takes one item per cycle while out_tready stays high.
// Every stage has its own valid bit and advances when it is empty or its
// successor advances, so bubbles close up while out_tready is low and
// in_tready drops only when the whole pipeline is full.
// Reset (rst_n low at a clock edge) empties all stages; data registers are not reset.
`default_nettype none
module swept_aabb_collision_time (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // rel_x, rel_y, rel_z, vel_x, vel_y, vel_z, a_width, a_height, a_depth,
  // b_width, b_height, b_depth, zero pad
  input  wire logic [sac_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // hit_time, normal_x, normal_y, normal_z, zero pad
  output logic [sac_pkg::OUT_TDATA_BITS-1:0]       out_tdata
);

  localparam int C  = sac_pkg::COORD_BITS;
  localparam int SZ = sac_pkg::SIZE_BITS;
  localparam int SM = sac_pkg::SUM_BITS;
  localparam int M  = sac_pkg::MAG_BITS;
  localparam int T  = sac_pkg::TIME_BITS;
  localparam int Q  = sac_pkg::QUO_BITS;
  localparam int NA = sac_pkg::NAXIS;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // ---------------- stage F1: input register
  logic                       f1_v_r;
  logic                       f1_rdy;
  logic signed [C-1:0]        f1_rel_r [NA];
  logic signed [C-1:0]        f1_vel_r [NA];
  logic        [SZ-1:0]       f1_asz_r [NA];
  logic        [SZ-1:0]       f1_bsz_r [NA];

  // ---------------- stage F2: broadphase and distances
  logic                       f2_v_r;
  logic                       f2_rdy;
  logic                       f2_bp_r;
  logic                       f2_bp_nxt;
  logic signed [SM-1:0]       f2_dent_r [NA];
  logic signed [SM-1:0]       f2_dx_r   [NA];
  logic signed [SM-1:0]       f2_dent_nxt [NA];
  logic signed [SM-1:0]       f2_dx_nxt   [NA];
  logic signed [C-1:0]        f2_vel_r  [NA];
  logic [NA-1:0]              f2_axis_ok;

  // ---------------- divider
  logic                       div_in_ready;
  logic                       div_out_valid;
  logic                       div_out_ready;
  sac_pkg::lanes_t            div_in_lanes;
  sac_pkg::side_t             div_in_side;
  sac_pkg::lanes_t            div_out_lanes;
  sac_pkg::side_t             div_out_side;

  // ---------------- back stages
  logic                       p1_v_r;
  logic                       p1_rdy;
  logic signed [T-1:0]        p1_t_r   [sac_pkg::NLANE];
  logic signed [T-1:0]        p1_t_nxt [sac_pkg::NLANE];
  sac_pkg::side_t             p1_side_r;

  logic                       p2_v_r;
  logic                       p2_rdy;
  logic signed [T-1:0]        p2_entry_r, p2_entry_nxt;
  logic signed [T-1:0]        p2_exit_r,  p2_exit_nxt;
  logic [1:0]                 p2_axis_r,  p2_axis_nxt;
  logic                       p2_bp_r;
  logic                       p2_dneg_r,  p2_dneg_nxt;

  logic                       out_v_r;
  logic                       out_rdy;
  logic [Q-1:0]               out_time_r, out_time_nxt;
  logic signed [1:0]          out_nrm_r   [NA];
  logic signed [1:0]          out_nrm_nxt [NA];

  // Ready chain
  assign out_rdy       = !out_v_r || out_tready;
  assign p2_rdy        = !p2_v_r || out_rdy;
  assign p1_rdy        = !p1_v_r || p2_rdy;
  assign div_out_ready = p1_rdy;
  assign f2_rdy        = !f2_v_r || div_in_ready;
  assign f1_rdy        = !f1_v_r || f2_rdy;
  assign in_tready     = f1_rdy;

  // F1: capture the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_rdy) begin
      f1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy && in_tvalid) begin
      for (int k = 0; k < NA; k++) begin
        f1_rel_r[k] <= in_tdata[k*C +: C];
        f1_vel_r[k] <= in_tdata[sac_pkg::VEL_OFS + k*C +: C];
        f1_asz_r[k] <= in_tdata[sac_pkg::ASZ_OFS + k*SZ +: SZ];
        f1_bsz_r[k] <= in_tdata[sac_pkg::BSZ_OFS + k*SZ +: SZ];
      end
    end
  end

  // F2: broadphase overlap test and entry/exit distances
  always_comb begin
    logic signed [SM-1:0] rel, vel, asz, bsz;
    for (int k = 0; k < NA; k++) begin
      rel = SM'(f1_rel_r[k]);
      vel = SM'(f1_vel_r[k]);
      asz = SM'($signed({1'b0, f1_asz_r[k]}));
      bsz = SM'($signed({1'b0, f1_bsz_r[k]}));
      f2_axis_ok[k] = !((vel + asz <= rel) || (vel >= rel + bsz));
      if (vel > 0) begin
        f2_dent_nxt[k] = rel - asz;
        f2_dx_nxt[k]   = rel + bsz;
      end else begin
        f2_dent_nxt[k] = rel + bsz;
        f2_dx_nxt[k]   = rel - asz;
      end
    end
    f2_bp_nxt = &f2_axis_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_rdy) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_rdy && f1_v_r) begin
      f2_bp_r   <= f2_bp_nxt;
      f2_dent_r <= f2_dent_nxt;
      f2_dx_r   <= f2_dx_nxt;
      f2_vel_r  <= f1_vel_r;
    end
  end

  // Set up division lanes: magnitudes, signs, saturation and zero velocity
  always_comb begin
    logic signed [SM-1:0] num;
    logic [M-1:0]         nm, dm;
    logic                 vneg;
    for (int l = 0; l < sac_pkg::NLANE; l++) begin
      num  = (l < NA) ? f2_dent_r[l % NA] : f2_dx_r[l % NA];
      vneg = f2_vel_r[l % NA] < 0;
      nm   = num[SM-1] ? M'(-num) : M'(num);
      dm   = vneg ? M'(-f2_vel_r[l % NA]) : M'(f2_vel_r[l % NA]);
      div_in_lanes[l].rem = {1'b0, nm};
      div_in_lanes[l].den = dm;
      div_in_lanes[l].quo = '0;
      div_in_lanes[l].sat = ({1'b0, nm} >= {dm, 1'b0});
      div_in_lanes[l].neg = num[SM-1] ^ vneg;
      div_in_lanes[l].unb = (f2_vel_r[l % NA] == '0);
    end
    div_in_side.bp_hit = f2_bp_r;
    for (int k = 0; k < NA; k++) begin
      div_in_side.dneg[k] = f2_dent_r[k][SM-1];
    end
  end

  sac_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f2_v_r),
    .in_ready  (div_in_ready),
    .in_lanes  (div_in_lanes),
    .in_side   (div_in_side),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_lanes (div_out_lanes),
    .out_side  (div_out_side)
  );

  // P1: signed times with saturation and unbounded axes
  always_comb begin
    logic signed [T-1:0] mag;
    for (int l = 0; l < sac_pkg::NLANE; l++) begin
      mag = div_out_lanes[l].sat ? sac_pkg::SAT_T : T'(div_out_lanes[l].quo);
      if (div_out_lanes[l].unb) begin
        p1_t_nxt[l] = (l < NA) ? -sac_pkg::UNB_T : sac_pkg::UNB_T;
      end else begin
        p1_t_nxt[l] = div_out_lanes[l].neg ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && div_out_valid) begin
      p1_t_r    <= p1_t_nxt;
      p1_side_r <= div_out_side;
    end
  end

  // P2: latest entry (first axis wins ties) and earliest exit
  always_comb begin
    p2_entry_nxt = p1_t_r[0];
    p2_axis_nxt  = AXIS_X;
    p2_dneg_nxt  = p1_side_r.dneg[0];
    if (p1_t_r[1] > p2_entry_nxt) begin
      p2_entry_nxt = p1_t_r[1];
      p2_axis_nxt  = AXIS_Y;
      p2_dneg_nxt  = p1_side_r.dneg[1];
    end
    if (p1_t_r[2] > p2_entry_nxt) begin
      p2_entry_nxt = p1_t_r[2];
      p2_axis_nxt  = AXIS_Z;
      p2_dneg_nxt  = p1_side_r.dneg[2];
    end
    p2_exit_nxt = p1_t_r[NA];
    if (p1_t_r[NA+1] < p2_exit_nxt) p2_exit_nxt = p1_t_r[NA+1];
    if (p1_t_r[NA+2] < p2_exit_nxt) p2_exit_nxt = p1_t_r[NA+2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy && p1_v_r) begin
      p2_entry_r <= p2_entry_nxt;
      p2_exit_r  <= p2_exit_nxt;
      p2_axis_r  <= p2_axis_nxt;
      p2_dneg_r  <= p2_dneg_nxt;
      p2_bp_r    <= p1_side_r.bp_hit;
    end
  end

  // P3: hit decision and result item
  always_comb begin
    logic miss;
    logic signed [1:0] nv;
    miss = !p2_bp_r || (p2_entry_r >= p2_exit_r) || (p2_entry_r < 0)
           || (p2_entry_r > sac_pkg::ONE_T);
    nv   = p2_dneg_r ? sac_pkg::NORM_POS : sac_pkg::NORM_NEG;
    out_time_nxt = miss ? Q'(sac_pkg::ONE_T) : p2_entry_r[Q-1:0];
    for (int k = 0; k < NA; k++) begin
      out_nrm_nxt[k] = (!miss && (p2_axis_r == 2'(k))) ? nv : sac_pkg::NORM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && p2_v_r) begin
      out_time_r <= out_time_nxt;
      out_nrm_r  <= out_nrm_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = sac_pkg::OUT_TDATA_BITS'({out_nrm_r[2], out_nrm_r[1], out_nrm_r[0],
                                                out_time_r});

endmodule
`default_nettype wire
